// ===== rtl/xs128p_pkg.sv =====
`timescale 1ns / 1ps

package xs128p_pkg;

  // Depth of the request queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Finalizer multipliers and shift.
  localparam logic [63:0] MIX_K1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_K2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;

  // Generator shifts.
  localparam int unsigned SHIFT_A = 23;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 26;

  // Value placed in word A when seeding leaves an all-zero state.
  localparam logic [63:0] ZERO_STATE_FIX = 64'h0123456789abcdef;

  // Reset value of the discard count register.
  localparam logic [7:0] DISCARD_RESET = 8'd4;

  // Seed byte counter marks: window full, and saturated (sliding).
  localparam logic [3:0] SEEN_FULL = 4'd8;
  localparam logic [3:0] SEEN_SAT  = 4'd9;

  typedef enum logic {
    REQ_DRAW = 1'b0,
    REQ_SEED = 1'b1
  } req_e;

  // One classified request as it sits in the queue.
  typedef struct packed {
    req_e       req;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MIX_A,
    BK_MIX_B,
    BK_FIX,
    BK_DISCARD
  } back_state_e;

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_LO,
    MX_CROSS_A,
    MX_CROSS_B,
    MX_SUM
  } mix_state_e;

  // New word B of one generator step, from the current words A and B.
  function automatic logic [63:0] step_next(input logic [63:0] s, input logic [63:0] t);
    logic [63:0] x;
    x = s ^ (s << SHIFT_A);
    return x ^ t ^ (x >> SHIFT_B) ^ (t >> SHIFT_C);
  endfunction

endpackage

// ===== rtl/xs128p_front.sv =====
`timescale 1ns / 1ps

module xs128p_front #(
  parameter int unsigned Depth = xs128p_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         seed_byte_i,
  input  logic               seed_last_i,
  output logic               item_valid_o,
  output xs128p_pkg::item_t  item_o,
  input  logic               item_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xs128p_pkg::item_t queue_q [Depth];
  xs128p_pkg::item_t item_in;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push;
  logic              pop;

  // Classify the incoming request into a queue entry.
  always_comb begin
    item_in.req  = xs128p_pkg::req_e'(req_type_i);
    item_in.data = seed_byte_i;
    item_in.last = seed_last_i;
  end

  assign in_stall_o   = (count_q == CntW'(Depth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && item_valid_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage is written on every accepted transfer.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== rtl/xs128p_mix.sv =====
`timescale 1ns / 1ps

module xs128p_mix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] operand_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  xs128p_pkg::mix_state_e state_q, state_d;
  logic [63:0] v_q, v_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] hi_q, hi_d;
  logic        round_q, round_d;
  logic        done_q, done_d;
  logic [63:0] k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] product;
  logic [63:0] sum;
  logic [63:0] mixed;

  // The first round multiplies by K1, the second by K2.
  assign k = round_q ? xs128p_pkg::MIX_K2 : xs128p_pkg::MIX_K1;

  // One shared 32x32 multiplier; the low 64 bits of the 64x64 product are
  // built from the low partial product and two cross terms.
  always_comb begin
    unique case (state_q)
      xs128p_pkg::MX_CROSS_A: begin
        mul_a = v_q[31:0];
        mul_b = k[63:32];
      end
      xs128p_pkg::MX_CROSS_B: begin
        mul_a = v_q[63:32];
        mul_b = k[31:0];
      end
      default: begin
        mul_a = v_q[31:0];
        mul_b = k[31:0];
      end
    endcase
  end

  assign product = mul_a * mul_b;
  assign sum     = prod_q + {hi_q, 32'h0};
  assign mixed   = sum ^ (sum >> xs128p_pkg::MIX_SHIFT);

  // Sequencer: load and pre-shift, then two multiply rounds.
  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    prod_d  = prod_q;
    hi_d    = hi_q;
    round_d = round_q;
    done_d  = 1'b0;
    unique case (state_q)
      xs128p_pkg::MX_IDLE: begin
        if (start_i) begin
          v_d     = operand_i ^ (operand_i >> xs128p_pkg::MIX_SHIFT);
          round_d = 1'b0;
          state_d = xs128p_pkg::MX_LO;
        end
      end
      xs128p_pkg::MX_LO: begin
        prod_d  = product;
        state_d = xs128p_pkg::MX_CROSS_A;
      end
      xs128p_pkg::MX_CROSS_A: begin
        hi_d    = product[31:0];
        state_d = xs128p_pkg::MX_CROSS_B;
      end
      xs128p_pkg::MX_CROSS_B: begin
        hi_d    = hi_q + product[31:0];
        state_d = xs128p_pkg::MX_SUM;
      end
      xs128p_pkg::MX_SUM: begin
        v_d = mixed;
        if (round_q) begin
          done_d  = 1'b1;
          state_d = xs128p_pkg::MX_IDLE;
        end else begin
          round_d = 1'b1;
          state_d = xs128p_pkg::MX_LO;
        end
      end
      default: begin
        state_d = xs128p_pkg::MX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xs128p_pkg::MX_IDLE;
      round_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    prod_q <= prod_d;
    hi_q   <= hi_d;
  end

  assign done_o   = done_q;
  assign result_o = v_q;

endmodule

// ===== rtl/xs128p_back.sv =====
`timescale 1ns / 1ps

module xs128p_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  xs128p_pkg::item_t  item_i,
  output logic               item_pop_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        random_value_o
);

  xs128p_pkg::back_state_e state_q, state_d;
  logic [63:0] word_a_q, word_a_d;
  logic [63:0] word_b_q, word_b_d;
  logic [63:0] window_q, window_d;
  logic [3:0]  seen_q, seen_d;
  logic [7:0]  discard_q, discard_d;
  logic [7:0]  count_q, count_d;
  logic        slide_q, slide_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;
  logic        out_free;
  logic [63:0] step_n;
  logic [63:0] win_fill;
  logic [63:0] win_slide;
  logic        mix_start;
  logic [63:0] mix_operand;
  logic        mix_done;
  logic [63:0] mix_result;

  xs128p_mix u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mix_start),
    .operand_i (mix_operand),
    .done_o    (mix_done),
    .result_o  (mix_result)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_n    = xs128p_pkg::step_next(word_a_q, word_b_q);
  assign win_fill  = window_q | ({56'h0, item_i.data} << {seen_q[2:0], 3'b000});
  assign win_slide = {item_i.data, window_q[63:8]};

  // Request execution: draws complete here when the output register is free, seed
  // bytes that complete or slide the window run two finalizer passes, the last
  // byte then applies the zero fix and the discard run.
  always_comb begin
    state_d     = state_q;
    word_a_d    = word_a_q;
    word_b_d    = word_b_q;
    window_d    = window_q;
    seen_d      = seen_q;
    discard_d   = discard_q;
    count_d     = count_q;
    slide_d     = slide_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    item_pop_o  = 1'b0;
    mix_start   = 1'b0;
    mix_operand = win_fill;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      discard_d = cfg_wdata_i;
    end

    unique case (state_q)
      xs128p_pkg::BK_IDLE: begin
        if (item_valid_i) begin
          if (item_i.req == xs128p_pkg::REQ_DRAW) begin
            if (out_free) begin
              item_pop_o  = 1'b1;
              word_a_d    = word_b_q;
              word_b_d    = step_n;
              out_valid_d = 1'b1;
              out_data_d  = step_n + word_b_q;
            end
          end else begin
            item_pop_o = 1'b1;
            last_d     = item_i.last;
            if (seen_q < xs128p_pkg::SEEN_FULL) begin
              window_d = win_fill;
              seen_d   = seen_q + 4'd1;
              slide_d  = 1'b0;
              if ((seen_q == xs128p_pkg::SEEN_FULL - 4'd1) || item_i.last) begin
                mix_start   = 1'b1;
                mix_operand = win_fill;
                state_d     = xs128p_pkg::BK_MIX_A;
              end
            end else begin
              window_d    = win_slide;
              seen_d      = xs128p_pkg::SEEN_SAT;
              slide_d     = 1'b1;
              mix_start   = 1'b1;
              mix_operand = word_a_q ^ win_slide;
              state_d     = xs128p_pkg::BK_MIX_A;
            end
          end
        end
      end
      xs128p_pkg::BK_MIX_A: begin
        if (mix_done) begin
          word_a_d    = mix_result;
          mix_start   = 1'b1;
          mix_operand = mix_result ^ (slide_q ? word_b_q : window_q);
          state_d     = xs128p_pkg::BK_MIX_B;
        end
      end
      xs128p_pkg::BK_MIX_B: begin
        if (mix_done) begin
          word_b_d = mix_result;
          state_d  = last_q ? xs128p_pkg::BK_FIX : xs128p_pkg::BK_IDLE;
        end
      end
      xs128p_pkg::BK_FIX: begin
        if ((word_a_q == '0) && (word_b_q == '0)) begin
          word_a_d = xs128p_pkg::ZERO_STATE_FIX;
        end
        window_d = '0;
        seen_d   = '0;
        count_d  = discard_q;
        state_d  = (discard_q == '0) ? xs128p_pkg::BK_IDLE : xs128p_pkg::BK_DISCARD;
      end
      xs128p_pkg::BK_DISCARD: begin
        word_a_d = word_b_q;
        word_b_d = step_n;
        count_d  = count_q - 8'd1;
        if (count_q == 8'd1) begin
          state_d = xs128p_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = xs128p_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xs128p_pkg::BK_IDLE;
      word_a_q    <= xs128p_pkg::ZERO_STATE_FIX;
      word_b_q    <= '0;
      window_q    <= '0;
      seen_q      <= '0;
      discard_q   <= xs128p_pkg::DISCARD_RESET;
      count_q     <= '0;
      slide_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_a_q    <= word_a_d;
      word_b_q    <= word_b_d;
      window_q    <= window_d;
      seen_q      <= seen_d;
      discard_q   <= discard_d;
      count_q     <= count_d;
      slide_q     <= slide_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The output data register holds its value while a transfer is stalled.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_data_q;

endmodule

// ===== rtl/xorshift128p_generator_hash_seeded_unit.sv =====
`timescale 1ns / 1ps

// xorshift128+ random generator with byte-serial hash seeding. A draw request
// returns one 64-bit word through the output register, so draws sustain one per
// cycle as long as the output is not stalled. A seed byte that only adds to
// the window leaves the back end free for the next request; a byte that
// completes the first eight, ends a shorter seed or slides the window runs two
// passes of the murmur3 finalizer through one shared 32x32 multiplier, which
// holds the back end. The last seed byte then applies the zero-state fix and
// drops discard_count generator steps. Requests wait in a short queue while
// seeding work is in progress, and discard_count (reset 4) should be written
// only while the block is idle.
module xorshift128p_generator_hash_seeded_unit #(
  parameter int unsigned QueueDepth = xs128p_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  seed_byte_i,
  input  logic        seed_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] random_value_o
);

  logic              item_valid;
  logic              item_pop;
  xs128p_pkg::item_t item;

  // Front: accepts and queues requests.
  xs128p_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .seed_byte_i  (seed_byte_i),
    .seed_last_i  (seed_last_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Back: generator state, seeding sequencer and output register.
  xs128p_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_pop_o     (item_pop),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_o (random_value_o)
  );

endmodule

// ===== verif/xorshift128p_generator_hash_seeded_unit_tb.sv =====
`timescale 1ns / 1ps

module xorshift128p_generator_hash_seeded_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  // Allow the longest discard run after a seed byte to finish, with a full
  // request queue behind it.
  localparam int unsigned DRAIN_CYCLES = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 246;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [7:0]  seed_byte_i;
  logic        seed_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] random_value_o;

  // Mirror of the generator state and the discard setting.
  logic [63:0] gen_a;
  logic [63:0] gen_b;
  logic [63:0] seed_win;
  logic [3:0]  seed_seen;
  logic [7:0]  discard_cfg;

  xs128p_pkg::item_t pending_reqs[$];
  logic [63:0] expected_words[$];
  int unsigned queued_count;
  int unsigned accepted_count;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned gap_left;

  xorshift128p_generator_hash_seeded_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .seed_byte_i    (seed_byte_i),
    .seed_last_i    (seed_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .random_value_o (random_value_o)
  );

  always #4 clk_i = ~clk_i;

  // Murmur3 64-bit finalizer.
  function automatic logic [63:0] murmur_fold(input logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * xs128p_pkg::MIX_K1;
    v = v ^ (v >> 33);
    v = v * xs128p_pkg::MIX_K2;
    return v ^ (v >> 33);
  endfunction

  // One xorshift128+ step on the mirrored words; returns the output word.
  function automatic logic [63:0] advance_xorshift();
    logic [63:0] x;
    logic [63:0] t;
    x = gen_a;
    t = gen_b;
    x = x ^ (x << 23);
    x = x ^ t ^ (x >> 17) ^ (t >> 26);
    gen_a = t;
    gen_b = x;
    return x + t;
  endfunction

  function automatic void load_seed_word(input logic [63:0] w);
    gen_a = murmur_fold(w);
    gen_b = murmur_fold(w ^ gen_a);
  endfunction

  // Applies one request to the mirrored state and queues any output word.
  function automatic void predict_request(input xs128p_pkg::item_t rq);
    if (rq.req == xs128p_pkg::REQ_DRAW) begin
      expected_words.push_back(advance_xorshift());
      return;
    end
    if (seed_seen < xs128p_pkg::SEEN_FULL) begin
      seed_win = seed_win | (64'(rq.data) << (8 * seed_seen));
      seed_seen = seed_seen + 4'd1;
      if (seed_seen == xs128p_pkg::SEEN_FULL || rq.last) begin
        load_seed_word(seed_win);
      end
    end else begin
      // Sliding window: the new byte enters at the top.
      seed_win = {rq.data, seed_win[63:8]};
      gen_a = murmur_fold(gen_a ^ seed_win);
      gen_b = murmur_fold(gen_a ^ gen_b);
      seed_seen = xs128p_pkg::SEEN_SAT;
    end
    if (rq.last) begin
      if (gen_a == 64'd0 && gen_b == 64'd0) begin
        gen_a = xs128p_pkg::ZERO_STATE_FIX;
      end
      for (int i = 0; i < int'(discard_cfg); i++) begin
        void'(advance_xorshift());
      end
      seed_win = 64'd0;
      seed_seen = 4'd0;
    end
  endfunction

  task automatic note_failure(input string what, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
    if (fail_count < 10) begin
      $display("[%0t] %s: expected %h, got %h", $time, what, exp_v, got_v);
    end
    fail_count++;
  endtask

  task automatic push_draw();
    xs128p_pkg::item_t rq;
    rq.req = xs128p_pkg::REQ_DRAW;
    // Seed fields are don't-care on a draw, so they carry noise.
    rq.data = 8'($urandom);
    rq.last = 1'($urandom);
    pending_reqs.push_back(rq);
    queued_count++;
  endtask

  task automatic push_seed(input logic [7:0] b, input logic last);
    xs128p_pkg::item_t rq;
    rq.req = xs128p_pkg::REQ_SEED;
    rq.data = b;
    rq.last = last;
    pending_reqs.push_back(rq);
    queued_count++;
  endtask

  // Waits until every queued request has been taken and every output word
  // has arrived, then lets any trailing seed work finish.
  task automatic wait_for_idle();
    while (accepted_count != queued_count || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_discard(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    discard_cfg = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly complete seeds and runs of draws, plus unterminated fragments
  // and stray seed bytes.
  task automatic queue_random_phase(input int unsigned n);
    int unsigned made;
    int unsigned sel;
    int unsigned len;
    logic        zero_seed;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        len = $urandom_range(1, 8);
        repeat (len) push_draw();
        made += len;
      end else if (sel < 85) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        zero_seed = ($urandom_range(0, 19) == 0);
        for (int k = 0; k < int'(len); k++) begin
          if ($urandom_range(0, 9) == 0) begin
            push_draw();
            made++;
          end
          push_seed(zero_seed ? 8'h00 : 8'($urandom), k == int'(len) - 1);
          made++;
        end
      end else if (sel < 93) begin
        len = $urandom_range(1, 12);
        repeat (len) push_seed(8'($urandom), 1'b0);
        made += len;
      end else begin
        push_seed(8'($urandom), 1'($urandom));
        made++;
      end
    end
    // A closing draw proves that all earlier seed work has completed.
    push_draw();
  endtask

  // Stimulus and configuration phases.
  initial begin
    logic [7:0] phase_cfg[5];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'd0;
    in_valid_i = 1'b0;
    req_type_i = 1'b0;
    seed_byte_i = 8'd0;
    seed_last_i = 1'b0;
    out_stall_i = 1'b0;
    gen_a = xs128p_pkg::ZERO_STATE_FIX;
    gen_b = 64'd0;
    seed_win = 64'd0;
    seed_seen = 4'd0;
    discard_cfg = xs128p_pkg::DISCARD_RESET;
    queued_count = 0;
    accepted_count = 0;
    cycle_count = 0;
    fail_count = 0;
    burst_left = 0;
    gap_left = 0;
    phase_cfg = '{8'd0, 8'd255, 8'($urandom_range(2, 254)), 8'd1,
                  8'($urandom_range(2, 254))};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: draws from the reset state with noisy seed fields.
    push_seed(8'h00, 1'b0);
    pending_reqs.delete();
    queued_count = 0;
    push_draw();
    push_draw();
    // An all-zero seed must trigger the zero-state replacement.
    push_seed(8'h00, 1'b1);
    push_draw();
    // Short seed with a draw in the middle.
    push_seed(8'hff, 1'b0);
    push_draw();
    push_seed(8'h80, 1'b1);
    push_draw();
    // Ten-byte seed: the window fills, then slides twice.
    for (int k = 1; k <= 10; k++) begin
      if (k == 10) begin
        push_draw();
      end
      push_seed(8'(k), k == 10);
    end
    push_draw();
    push_draw();
    wait_for_idle();

    foreach (phase_cfg[p]) begin
      write_discard(phase_cfg[p]);
      queue_random_phase(ITEMS_PER_PHASE);
      wait_for_idle();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Sender: bursts of transfers, short ones separated by random gaps.
  always @(posedge clk_i) begin
    xs128p_pkg::item_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        accepted_count++;
      end
      if (in_valid_i && in_stall_o !== 1'b0) begin
        // Stalled: hold the payload.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur = pending_reqs.pop_front();
        req_type_i <= cur.req;
        seed_byte_i <= cur.data;
        seed_last_i <= cur.last;
        in_valid_i <= 1'b1;
        predict_request(cur);
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(40, 120);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern changes with bits 8:7 of the cycle count.
  always @(posedge clk_i) begin
    case (cycle_count[8:7])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2'd2: out_stall_i <= ((cycle_count % 11) < 4);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Compare each output transfer with the oldest expected word.
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_words.size() == 0) begin
        note_failure("unexpected output", 64'd0, random_value_o);
      end else begin
        want = expected_words.pop_front();
        if (random_value_o !== want) begin
          note_failure("random_value mismatch", want, random_value_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// ===== xorshift128p_generator_hash_seeded_unit.f =====
rtl/xs128p_pkg.sv
rtl/xs128p_front.sv
rtl/xs128p_mix.sv
rtl/xs128p_back.sv
rtl/xorshift128p_generator_hash_seeded_unit.sv
verif/xorshift128p_generator_hash_seeded_unit_tb.sv
